// ===== hw/rtl/cassette_block_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cassette block deframer
// Shared helpers so that every checking module writes its properties alike.
// ----------------------------------------------------------------------------
`ifndef CASSETTE_BLOCK_DEFRAMER_MACROS_SVH
`define CASSETTE_BLOCK_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and constants shared by the cassette block deframer modules.
// ----------------------------------------------------------------------------
package cbd_pkg;

	// Tape format bytes.
	localparam logic [7:0] SYNC_BYTE      = 8'h3C;
	localparam logic [7:0] SKIP_BYTE      = 8'h5A;
	localparam logic [7:0] HEADER_TYPE    = 8'h00;
	localparam logic [7:0] EOF_TYPE       = 8'hFF;
	localparam logic [7:0] HEADER_MIN_LEN = 8'd14;
	localparam logic [7:0] HDR_FIRST      = 8'd8;
	localparam int         HDR_BYTES      = 6;
	localparam logic [15:0] TOTAL_MAX     = 16'hFFFF;

	// Deframer phase.
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SYNCED  = 3'd1,
		PH_TYPE    = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	// Result codes.
	typedef enum logic [2:0] {
		KIND_PAYLOAD   = 3'd0,
		KIND_BLOCK_OK  = 3'd1,
		KIND_STREAM_OK = 3'd2,
		KIND_CHK_BAD   = 3'd3,
		KIND_TRUNCATED = 3'd4,
		KIND_NO_BLOCKS = 3'd5,
		KIND_EMPTY     = 3'd6
	} kind_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  block_kind;
		logic [7:0]  block_length;
		logic [7:0]  computed_sum;
		logic [15:0] blocks_accepted;
		logic [7:0]  file_kind;
		logic [7:0]  file_mode;
		logic [15:0] load_address;
		logic [15:0] run_address;
	} result_t;

endpackage

// ===== hw/rtl/cbd_in_stage.sv =====
// ----------------------------------------------------------------------------
// cbd_in_stage
// Input register: captures one item per transfer and holds it until the
// deframer engine consumes it.
// ----------------------------------------------------------------------------
module cbd_in_stage
	import cbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic load;

	// The register can take a new item when empty or when its item moves on.
	assign item_ready = !valid_s1 || advance;
	assign load       = item_valid && item_ready;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Item payload.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.mode      <= mode;
			item_s1.data_byte <= data_byte;
		end
	end

endmodule

// ===== hw/rtl/cbd_engine.sv =====
`include "cassette_block_deframer_macros.svh"
// ----------------------------------------------------------------------------
// cbd_engine
// Block parser state: walks sync, type, length, payload and checksum, keeps
// the running sum, block count and header fields, and forms each result.
// ----------------------------------------------------------------------------
module cbd_engine
	import cbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output logic    emit,
	output result_t res
);

	phase_t      phase_q, phase_d;
	logic        seen_any_q, seen_any_d;
	logic        failed_q, failed_d;
	logic [7:0]  cur_type_q, cur_type_d;
	logic [7:0]  cur_length_q, cur_length_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic [15:0] block_total_q, block_total_d;
	logic [7:0]  header_kind_q, header_kind_d;
	logic [7:0]  header_mode_q, header_mode_d;
	logic [15:0] header_load_q, header_load_d;
	logic [15:0] header_run_q, header_run_d;
	logic [7:0]  stage_q [HDR_BYTES];
	logic [7:0]  stage_d [HDR_BYTES];

	logic [7:0]  b;
	logic [7:0]  sum_plus;
	logic [7:0]  count_plus;
	kind_t       kind;
	logic [7:0]  pbyte;
	logic [7:0]  pindex;
	kind_t       eos_kind;

	assign b          = item.data_byte;
	assign sum_plus   = running_sum_q + b;
	assign count_plus = byte_count_q + 8'd1;

	// End-of-stream status, first matching condition wins.
	always_comb begin
		if (!seen_any_q) begin
			eos_kind = KIND_EMPTY;
		end else if (failed_q) begin
			eos_kind = KIND_CHK_BAD;
		end else if (phase_q != PH_HUNT && phase_q != PH_DONE) begin
			eos_kind = KIND_TRUNCATED;
		end else if (block_total_q == 16'd0) begin
			eos_kind = KIND_NO_BLOCKS;
		end else begin
			eos_kind = KIND_STREAM_OK;
		end
	end

	// Next-state logic: the state after taking the current item.
	always_comb begin
		phase_d       = phase_q;
		seen_any_d    = seen_any_q;
		failed_d      = failed_q;
		cur_type_d    = cur_type_q;
		cur_length_d  = cur_length_q;
		byte_count_d  = byte_count_q;
		running_sum_d = running_sum_q;
		block_total_d = block_total_q;
		header_kind_d = header_kind_q;
		header_mode_d = header_mode_q;
		header_load_d = header_load_q;
		header_run_d  = header_run_q;
		stage_d       = stage_q;

		if (!item.mode) begin
			seen_any_d = 1'b1;
			unique case (phase_q)
				PH_HUNT: begin
					if (b == SYNC_BYTE) begin
						phase_d = PH_SYNCED;
					end
				end
				PH_SYNCED, PH_TYPE: begin
					if (phase_q == PH_SYNCED && b == SKIP_BYTE) begin
						phase_d = PH_TYPE;
					end else begin
						// This byte is the block type: open a new block.
						cur_type_d    = b;
						cur_length_d  = 8'd0;
						running_sum_d = b;
						byte_count_d  = 8'd0;
						for (int i = 0; i < HDR_BYTES; i++) begin
							stage_d[i] = 8'd0;
						end
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					cur_length_d  = b;
					running_sum_d = sum_plus;
					byte_count_d  = 8'd0;
					phase_d       = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					running_sum_d = sum_plus;
					for (int i = 0; i < HDR_BYTES; i++) begin
						if (byte_count_q == HDR_FIRST + 8'(i)) begin
							stage_d[i] = b;
						end
					end
					byte_count_d = count_plus;
					if (count_plus == cur_length_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (b != running_sum_q) begin
						failed_d = 1'b1;
						phase_d  = PH_DONE;
					end else begin
						if (block_total_q != TOTAL_MAX) begin
							block_total_d = block_total_q + 16'd1;
						end
						// Commit the staged header fields of a header block.
						if (cur_type_q == HEADER_TYPE && cur_length_q >= HEADER_MIN_LEN) begin
							header_kind_d = stage_q[0];
							header_mode_d = stage_q[1];
							header_load_d = {stage_q[2], stage_q[3]};
							header_run_d  = {stage_q[4], stage_q[5]};
						end
						phase_d = (cur_type_q == EOF_TYPE) ? PH_DONE : PH_HUNT;
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	// Output logic: whether a result is due, and its code.
	always_comb begin
		emit   = 1'b0;
		kind   = KIND_PAYLOAD;
		pbyte  = 8'd0;
		pindex = 8'd0;
		if (item.mode) begin
			emit = 1'b1;
			kind = eos_kind;
		end else begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					emit   = 1'b1;
					kind   = KIND_PAYLOAD;
					pbyte  = b;
					pindex = byte_count_q;
				end
				PH_CHECK: begin
					emit = 1'b1;
					kind = (b != running_sum_q) ? KIND_CHK_BAD : KIND_BLOCK_OK;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// Result fields reflect the state after the item (unchanged at end of stream).
	always_comb begin
		res.kind            = kind;
		res.payload_byte    = pbyte;
		res.payload_index   = pindex;
		res.block_kind      = cur_type_d;
		res.block_length    = cur_length_d;
		res.computed_sum    = running_sum_d;
		res.blocks_accepted = block_total_d;
		res.file_kind       = header_kind_d;
		res.file_mode       = header_mode_d;
		res.load_address    = header_load_d;
		res.run_address     = header_run_d;
	end

	// State registers; an end-of-stream item returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			seen_any_q    <= 1'b0;
			failed_q      <= 1'b0;
			cur_type_q    <= 8'd0;
			cur_length_q  <= 8'd0;
			byte_count_q  <= 8'd0;
			running_sum_q <= 8'd0;
			block_total_q <= 16'd0;
			header_kind_q <= 8'd0;
			header_mode_q <= 8'd0;
			header_load_q <= 16'd0;
			header_run_q  <= 16'd0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				stage_q[i] <= 8'd0;
			end
		end else if (step && item.mode) begin
			phase_q       <= PH_HUNT;
			seen_any_q    <= 1'b0;
			failed_q      <= 1'b0;
			cur_type_q    <= 8'd0;
			cur_length_q  <= 8'd0;
			byte_count_q  <= 8'd0;
			running_sum_q <= 8'd0;
			block_total_q <= 16'd0;
			header_kind_q <= 8'd0;
			header_mode_q <= 8'd0;
			header_load_q <= 16'd0;
			header_run_q  <= 16'd0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				stage_q[i] <= 8'd0;
			end
		end else if (step) begin
			phase_q       <= phase_d;
			seen_any_q    <= seen_any_d;
			failed_q      <= failed_d;
			cur_type_q    <= cur_type_d;
			cur_length_q  <= cur_length_d;
			byte_count_q  <= byte_count_d;
			running_sum_q <= running_sum_d;
			block_total_q <= block_total_d;
			header_kind_q <= header_kind_d;
			header_mode_q <= header_mode_d;
			header_load_q <= header_load_d;
			header_run_q  <= header_run_d;
			stage_q       <= stage_d;
		end
	end

	// A checksum failure always parks the parser.
	`CBD_ASSERT_SAME(a_failed_parks, failed_q, phase_q == PH_DONE, "failed but not stopped")
	// Payload indices stay inside the declared block length.
	`CBD_ASSERT_SAME(a_index_in_len, step && emit && kind == KIND_PAYLOAD,
		pindex < cur_length_q, "payload index beyond block length")
	// End of stream leaves the parser hunting with no history.
	`CBD_ASSERT_NEXT(a_eos_resets, step && item.mode,
		phase_q == PH_HUNT && !seen_any_q && block_total_q == 16'd0, "no reset after end of stream")

endmodule

// ===== hw/rtl/cassette_block_deframer.sv =====
// ----------------------------------------------------------------------------
// cassette_block_deframer
// Splits a raw cassette byte stream into blocks and reports each payload byte
// and each block or stream status.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_ready) carries one raw tape byte per
//   transfer (mode 0) or an end-of-stream marker (mode 1). The result channel
//   (result_valid/result_ready) carries at most one result per item: a payload
//   byte with its index, a block status, or the final stream status.
//   An item sits in the input register after its transfer, and its result is
//   loaded into the output register once that register has room; the
//   receiver takes it from there. Throughput: one item per cycle while the
//   receiver does not stall; each item's work is a single pass through the
//   parser logic, with 8-bit adds for the running sum and byte count.
//   Items that give no result (leader, sync, type, length) still pass through
//   the input register at one per cycle while no result is stalled.
//   While the receiver stalls, the result is held and the input register can
//   still take one more item; after that item_ready falls until the result is
//   taken.
//   Reset empties both registers and returns the parser to sync hunting. An
//   end-of-stream item reports its status and then resets the parser likewise.
// ----------------------------------------------------------------------------
`include "cassette_block_deframer_macros.svh"
module cassette_block_deframer
	import cbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [7:0]  block_kind,
	output logic [7:0]  block_length,
	output logic [7:0]  computed_sum,
	output logic [15:0] blocks_accepted,
	output logic [7:0]  file_kind,
	output logic [7:0]  file_mode,
	output logic [15:0] load_address,
	output logic [15:0] run_address
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    advance;
	logic    emit;
	result_t res;
	result_t res_q;
	logic    result_valid_q;

	// The held item moves on once the output register has room.
	assign out_free = !result_valid_q || result_ready;
	assign advance  = valid_s1 && out_free;

	cbd_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.data_byte  (data_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	cbd_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign result_valid    = result_valid_q;
	assign kind            = res_q.kind;
	assign payload_byte    = res_q.payload_byte;
	assign payload_index   = res_q.payload_index;
	assign block_kind      = res_q.block_kind;
	assign block_length    = res_q.block_length;
	assign computed_sum    = res_q.computed_sum;
	assign blocks_accepted = res_q.blocks_accepted;
	assign file_kind       = res_q.file_kind;
	assign file_mode       = res_q.file_mode;
	assign load_address    = res_q.load_address;
	assign run_address     = res_q.run_address;

	// A held item is never dropped while the output stalls.
	`CBD_ASSERT_NEXT(a_item_kept, valid_s1 && !out_free, valid_s1, "held item lost during stall")
	// A full input register with a stalled output refuses new transfers.
	`CBD_ASSERT_SAME(a_no_overrun, valid_s1 && !out_free, !item_ready, "input overrun")
	// A stalled result stays offered and unchanged.
	`CBD_ASSERT_NEXT(a_result_held, result_valid_q && !result_ready, result_valid_q && $stable(res_q), "stalled result changed")

endmodule

// ===== dv/cassette_block_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// cassette_block_deframer_tb
// Self-checking bench for the cassette block deframer. A directed table walks
// the block statuses, the header capture and the corner cases of the tape
// format, then random tape streams are pushed through under several idling
// patterns and one long receiver hold-off. Every result is checked field by
// field against a behavioural model of the deframer kept here.
// ----------------------------------------------------------------------------
module cassette_block_deframer_tb
	import cbd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] LEADER_BYTE  = 8'h01;
	localparam int         QUIET_LIMIT  = 4000;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         PHASE_ITEMS  = 450;
	localparam int         NUM_DIRECTED = 35;

	// One tape item as queued for the driver, with an optional typed status.
	typedef struct packed {
		logic       is_end;
		logic [7:0] value;
		logic       typed;
		kind_t      want;
	} tape_item_t;

	// Directed rows: a typed status stands only where it is plain to see.
	localparam tape_item_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{1'b1, 8'hFF, 1'b1, KIND_EMPTY},
		'{1'b0, 8'hFF, 1'b0, KIND_PAYLOAD},
		'{1'b1, 8'h00, 1'b1, KIND_NO_BLOCKS},
		// Double skip byte: the second one is the type; zero length.
		'{1'b0, 8'h3C, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h5A, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h5A, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h00, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h5A, 1'b1, KIND_BLOCK_OK},
		'{1'b1, 8'h80, 1'b1, KIND_STREAM_OK},
		// Header block of fourteen bytes with no skip byte.
		'{1'b0, 8'h3C, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h00, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h0E, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h00, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h01, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h02, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h03, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h04, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h05, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h06, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h07, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'hAB, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'hCD, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h12, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h34, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h56, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h78, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'hB6, 1'b1, KIND_BLOCK_OK},
		// End-of-file block with a wrong checksum, then a byte after the stop.
		'{1'b0, 8'h3C, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'hFF, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h00, 1'b0, KIND_PAYLOAD},
		'{1'b0, 8'h00, 1'b1, KIND_CHK_BAD},
		'{1'b0, 8'h3C, 1'b0, KIND_PAYLOAD},
		'{1'b1, 8'h7F, 1'b1, KIND_CHK_BAD},
		// Stream cut short just after a sync byte.
		'{1'b0, 8'h3C, 1'b0, KIND_PAYLOAD},
		'{1'b1, 8'h00, 1'b1, KIND_TRUNCATED}
	};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	logic        mode         = 1'b0;
	logic [7:0]  data_byte    = 8'h00;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [7:0]  block_kind;
	logic [7:0]  block_length;
	logic [7:0]  computed_sum;
	logic [15:0] blocks_accepted;
	logic [7:0]  file_kind;
	logic [7:0]  file_mode;
	logic [15:0] load_address;
	logic [15:0] run_address;

	tape_item_t tape_q [$];
	tape_item_t offered_item = '0;
	result_t    status_store [$];
	int         send_idle_pct = 0;
	int         stall_pct     = 0;
	logic       hold_ask      = 1'b0;
	logic       hold_seen     = 1'b0;
	int         hold_left     = 0;
	int         quiet_cycles  = 0;
	int         mismatches    = 0;

	// Deframer state as the bench sees it.
	phase_t      tape_phase;
	logic        any_byte_seen;
	logic        stream_failed;
	logic [7:0]  blk_type;
	logic [7:0]  blk_len;
	logic [7:0]  blk_count;
	logic [7:0]  blk_sum;
	logic [15:0] ok_blocks;
	logic [7:0]  hdr_kind;
	logic [7:0]  hdr_mode;
	logic [15:0] hdr_load;
	logic [15:0] hdr_run;
	logic [7:0]  hdr_stage [HDR_BYTES];

	cassette_block_deframer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.mode            (mode),
		.data_byte       (data_byte),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.kind            (kind),
		.payload_byte    (payload_byte),
		.payload_index   (payload_index),
		.block_kind      (block_kind),
		.block_length    (block_length),
		.computed_sum    (computed_sum),
		.blocks_accepted (blocks_accepted),
		.file_kind       (file_kind),
		.file_mode       (file_mode),
		.load_address    (load_address),
		.run_address     (run_address)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Return the deframer to sync hunting with every register cleared.
	task automatic clear_deframer();
		tape_phase    = PH_HUNT;
		any_byte_seen = 1'b0;
		stream_failed = 1'b0;
		blk_type      = 8'h00;
		blk_len       = 8'h00;
		blk_count     = 8'h00;
		blk_sum       = 8'h00;
		ok_blocks     = 16'h0000;
		hdr_kind      = 8'h00;
		hdr_mode      = 8'h00;
		hdr_load      = 16'h0000;
		hdr_run       = 16'h0000;
		for (int i = 0; i < HDR_BYTES; i++)
			hdr_stage[i] = 8'h00;
	endtask

	function automatic result_t snapshot(kind_t k, logic [7:0] pbyte, logic [7:0] pidx);
		result_t r;
		r.kind            = k;
		r.payload_byte    = pbyte;
		r.payload_index   = pidx;
		r.block_kind      = blk_type;
		r.block_length    = blk_len;
		r.computed_sum    = blk_sum;
		r.blocks_accepted = ok_blocks;
		r.file_kind       = hdr_kind;
		r.file_mode       = hdr_mode;
		r.load_address    = hdr_load;
		r.run_address     = hdr_run;
		return r;
	endfunction

	// Advance the deframer by one tape item and give the status it reports.
	task automatic deframe_step(input logic is_end, input logic [7:0] b,
			output logic emitted, output result_t r);
		logic [7:0] idx;
		kind_t      k;
		emitted = 1'b0;
		r       = '0;
		if (is_end) begin
			if (!any_byte_seen)
				k = KIND_EMPTY;
			else if (stream_failed)
				k = KIND_CHK_BAD;
			else if (tape_phase >= PH_SYNCED && tape_phase <= PH_CHECK)
				k = KIND_TRUNCATED;
			else if (ok_blocks == 16'h0000)
				k = KIND_NO_BLOCKS;
			else
				k = KIND_STREAM_OK;
			r       = snapshot(k, 8'h00, 8'h00);
			emitted = 1'b1;
			clear_deframer();
			return;
		end
		any_byte_seen = 1'b1;
		case (tape_phase)
			PH_HUNT: begin
				if (b == SYNC_BYTE)
					tape_phase = PH_SYNCED;
			end
			PH_SYNCED, PH_TYPE: begin
				// Only the first skip byte after a sync is dropped.
				if (tape_phase == PH_SYNCED && b == SKIP_BYTE) begin
					tape_phase = PH_TYPE;
				end else begin
					blk_type  = b;
					blk_len   = 8'h00;
					blk_sum   = b;
					blk_count = 8'h00;
					for (int i = 0; i < HDR_BYTES; i++)
						hdr_stage[i] = 8'h00;
					tape_phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				blk_len    = b;
				blk_sum    = blk_sum + b;
				blk_count  = 8'h00;
				tape_phase = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				idx     = blk_count;
				blk_sum = blk_sum + b;
				if (idx >= HDR_FIRST && idx < HDR_FIRST + HDR_BYTES)
					hdr_stage[idx - HDR_FIRST] = b;
				blk_count = idx + 8'd1;
				if (blk_count == blk_len)
					tape_phase = PH_CHECK;
				r       = snapshot(KIND_PAYLOAD, b, idx);
				emitted = 1'b1;
			end
			PH_CHECK: begin
				if (b != blk_sum) begin
					stream_failed = 1'b1;
					tape_phase    = PH_DONE;
					r = snapshot(KIND_CHK_BAD, 8'h00, 8'h00);
				end else begin
					if (ok_blocks != TOTAL_MAX)
						ok_blocks = ok_blocks + 16'd1;
					// Header fields are committed only by a good header block.
					if (blk_type == HEADER_TYPE && blk_len >= HEADER_MIN_LEN) begin
						hdr_kind = hdr_stage[0];
						hdr_mode = hdr_stage[1];
						hdr_load = {hdr_stage[2], hdr_stage[3]};
						hdr_run  = {hdr_stage[4], hdr_stage[5]};
					end
					tape_phase = (blk_type == EOF_TYPE) ? PH_DONE : PH_HUNT;
					r = snapshot(KIND_BLOCK_OK, 8'h00, 8'h00);
				end
				emitted = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic queue_raw(input logic [7:0] b);
		tape_item_t t;
		t = '{1'b0, b, 1'b0, KIND_PAYLOAD};
		tape_q.insert(tape_q.size(), t);
	endtask

	task automatic queue_end();
		tape_item_t t;
		t = '{1'b1, 8'h00, 1'b0, KIND_PAYLOAD};
		t.value = 8'($urandom_range(255));
		tape_q.insert(tape_q.size(), t);
	endtask

	// Queue one block, mostly well formed; it may be cut short or carry a bad sum.
	task automatic queue_block(output logic cut_short, output logic halted);
		logic [7:0] btype;
		logic [7:0] blen;
		logic [7:0] csum;
		logic [7:0] b;
		logic       bad;
		logic [7:0] parts [$];
		int         pick;
		int         n;
		pick = $urandom_range(99);
		if (pick < 20) begin
			btype = HEADER_TYPE;
			blen  = ($urandom_range(3) == 0) ? 8'($urandom_range(13))
				: 8'($urandom_range(24, 14));
		end else if (pick < 30) begin
			btype = EOF_TYPE;
			blen  = 8'($urandom_range(6));
		end else begin
			btype = 8'($urandom_range(255));
			blen  = ($urandom_range(99) == 0) ? 8'd255 : 8'($urandom_range(12));
		end
		parts.insert(parts.size(), SYNC_BYTE);
		if (btype == SKIP_BYTE || $urandom_range(1) == 1)
			parts.insert(parts.size(), SKIP_BYTE);
		parts.insert(parts.size(), btype);
		parts.insert(parts.size(), blen);
		csum = btype + blen;
		for (int i = 0; i < blen; i++) begin
			b = 8'($urandom_range(255));
			parts.insert(parts.size(), b);
			csum = csum + b;
		end
		bad = ($urandom_range(9) == 0);
		if (bad)
			csum = csum + 8'($urandom_range(255, 1));
		parts.insert(parts.size(), csum);
		cut_short = ($urandom_range(99) < 7);
		n = cut_short ? $urandom_range(parts.size() - 1, 1) : parts.size();
		for (int i = 0; i < n; i++)
			queue_raw(parts[i]);
		halted = bad || btype == EOF_TYPE;
	endtask

	// Random tape streams: leader, a few blocks, usually an end-of-stream mark.
	task automatic queue_streams(input int n_items);
		int   start;
		int   nblk;
		logic cut;
		logic halted;
		start = tape_q.size();
		while (tape_q.size() - start < n_items) begin
			if ($urandom_range(99) < 4)
				queue_end();
			repeat ($urandom_range(4)) queue_raw(LEADER_BYTE);
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(3, 1)) queue_raw(8'($urandom_range(255)));
			nblk   = $urandom_range(4);
			cut    = 1'b0;
			halted = 1'b0;
			for (int k = 0; k < nblk && !cut && !halted; k++)
				queue_block(cut, halted);
			// Bytes after a stop must change nothing.
			if (halted && !cut)
				repeat ($urandom_range(2)) queue_raw(8'($urandom_range(255)));
			if ($urandom_range(99) < 90)
				queue_end();
		end
	endtask

	task automatic wait_drained();
		while (tape_q.size() != 0 || item_valid || status_store.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Sender: offers the next queued item and models the deframer on each transfer.
	always @(posedge clk) begin
		logic    emitted;
		result_t r;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				deframe_step(offered_item.is_end, offered_item.value, emitted, r);
				if (emitted) begin
					if (offered_item.typed)
						r.kind = offered_item.want;
					status_store.insert(status_store.size(), r);
				end
			end
			if (!item_valid || item_ready) begin
				if (tape_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_item <= tape_q[0];
					mode         <= tape_q[0].is_end;
					data_byte    <= tape_q[0].value;
					item_valid   <= 1'b1;
					void'(tape_q.pop_front());
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_ask != hold_seen) begin
				hold_seen    <= hold_ask;
				hold_left    <= HOLD_CYCLES;
				result_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Each result transfer is compared with the oldest expected status.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (status_store.size() == 0) begin
				$error("result with nothing expected: kind %0d", kind);
				mismatches++;
			end else begin
				want = status_store.pop_front();
				check_field("kind", want.kind, kind);
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("payload_index", want.payload_index, payload_index);
				check_field("block_kind", want.block_kind, block_kind);
				check_field("block_length", want.block_length, block_length);
				check_field("computed_sum", want.computed_sum, computed_sum);
				check_field("blocks_accepted", want.blocks_accepted, blocks_accepted);
				check_field("file_kind", want.file_kind, file_kind);
				check_field("file_mode", want.file_mode, file_mode);
				check_field("load_address", want.load_address, load_address);
				check_field("run_address", want.run_address, run_address);
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL cassette_block_deframer");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int send_plan  [4];
		int stall_plan [4];
		send_plan  = '{0, 55, 0, 23};
		stall_plan = '{0, 0, 55, 23};
		clear_deframer();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int i = 0; i < NUM_DIRECTED; i++)
			tape_q.insert(tape_q.size(), DIRECTED_ROWS[i]);
		wait_drained();

		// Random streams under each idling pattern; the last one gets a hold-off.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct <= send_plan[p];
			stall_pct     <= stall_plan[p];
			@(posedge clk);
			queue_streams(PHASE_ITEMS);
			if (p == 3) begin
				while (tape_q.size() > PHASE_ITEMS / 2)
					@(posedge clk);
				hold_ask <= ~hold_ask;
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS cassette_block_deframer");
		else
			$display("FAIL cassette_block_deframer");
		$finish;
	end

endmodule
